// ----- rtl/core/gdd_pkg.sv -----
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types, constants and helper functions for the date difference block
// ----------------------------------------------------------------------------
`default_nettype none

package gdd_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned DIFF_W   = 23;
  localparam int unsigned DNUM_W   = 23;   // absolute day number, year 16383 still fits
  localparam int unsigned CUM_W    = 10;   // days before month plus day of month
  localparam int unsigned QUOT_W   = 8;    // quotient by 100 of a 15 bit value below 25600
  localparam int unsigned DIVIN_W  = 15;

  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
  localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
  localparam logic [12:0] DIV100_MUL      = 13'd5243;   // ceil(2^19 / 100)
  localparam int unsigned DIV100_SHIFT    = 19;

  localparam logic signed [DIFF_W:0] DIFF_MAX = 24'sd4194303;
  localparam logic signed [DIFF_W:0] DIFF_MIN = -24'sd4194304;

  typedef struct packed {
    logic [YEAR_W-1:0]  year_a;
    logic [MONTH_W-1:0] month_a;
    logic [DAY_W-1:0]   day_a;
    logic [YEAR_W-1:0]  year_b;
    logic [MONTH_W-1:0] month_b;
    logic [DAY_W-1:0]   day_b;
  } gdd_in_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] day_diff;
    logic                     a_after_b;
    logic                     a_before_b;
  } gdd_out_t;

  // exact floor(x / 100) for x below 25600
  function automatic logic [QUOT_W-1:0] div100(input logic [DIVIN_W-1:0] x);
    logic [27:0] prod;
    prod = {13'd0, x} * {15'd0, DIV100_MUL};
    return prod[DIV100_SHIFT+QUOT_W-1:DIV100_SHIFT];
  endfunction

  // days in the months before month index mi (0 is January, 12 is a full year)
  function automatic logic [8:0] cum_days(input logic [3:0] mi);
    logic [8:0] d;
    case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = DAYS_PER_YEAR;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gdd_day_num.sv -----
// ----------------------------------------------------------------------------
// gdd_day_num
// Two stage absolute day number of one date, counted from year zero
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_day_num (
  input  wire logic                         clk,
  input  wire logic [gdd_pkg::YEAR_W-1:0]   year,
  input  wire logic [gdd_pkg::MONTH_W-1:0]  month,
  input  wire logic [gdd_pkg::DAY_W-1:0]    day,
  output logic      [gdd_pkg::DNUM_W-1:0]   day_num
);
  import gdd_pkg::*;

  logic [YEAR_W-1:0]  c4;        // ceil(y / 4)
  logic [QUOT_W-1:0]  c100;      // ceil(y / 100)
  logic [QUOT_W-1:0]  c400;      // ceil(y / 400)
  logic [QUOT_W-1:0]  f100;      // floor(y / 100)
  logic [QUOT_W-1:0]  f400q;     // floor(ceil(y / 4) / 100)
  logic               leap;
  logic [3:0]         mi;
  logic [CUM_W-1:0]   cum;

  logic [DNUM_W-1:0]  y365_r;
  logic [YEAR_W-1:0]  c4_r;
  logic [QUOT_W-1:0]  c100_r;
  logic [QUOT_W-1:0]  c400_r;
  logic [CUM_W-1:0]   cum_r;
  logic [DNUM_W-1:0]  day_num_r;

  always_comb begin
    c4    = YEAR_W'(({1'b0, year} + 15'd3) >> 2);
    c100  = div100({1'b0, year} + 15'd99);
    c400  = div100({1'b0, c4} + 15'd99);
    f100  = div100({1'b0, year});
    f400q = div100({1'b0, c4});
    // divisible by 4, and either not by 100 or by 400
    leap  = (year[1:0] == 2'b00) && ((f100 != c100) || (f400q == c400));
    if (month == '0) begin
      mi = 4'd0;
    end else if (month > MONTHS_PER_YEAR) begin
      mi = MONTHS_PER_YEAR;
    end else begin
      mi = month - 4'd1;
    end
    cum = CUM_W'(cum_days(mi)) + CUM_W'(day) + CUM_W'(leap && (mi >= 4'd2));
  end

  always_ff @(posedge clk) begin
    y365_r <= DNUM_W'(year) * DNUM_W'(DAYS_PER_YEAR);
    c4_r   <= c4;
    c100_r <= c100;
    c400_r <= c400;
    cum_r  <= cum;
  end

  always_ff @(posedge clk) begin
    day_num_r <= y365_r + DNUM_W'(c4_r) - DNUM_W'(c100_r) + DNUM_W'(c400_r)
                 + DNUM_W'(cum_r);
  end

  assign day_num = day_num_r;

endmodule

`default_nettype wire

// ----- rtl/core/gregorian_date_difference.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_difference
// Signed day count from date B to date A with ordering flags
// ----------------------------------------------------------------------------
//
//   channel   ports                       direction  transfer when
//   input     start, busy, in_data        in         start high, busy low
//   result    out_valid, out_data         out        out_valid high
//
// one date pair per cycle
// pipeline: input register, day number terms, day numbers, difference/saturate
// reset is synchronous active low and clears the valid chain; busy is high
// only while reset is held
// the receiver cannot stall; each result shows for one cycle only
//
`default_nettype none

module gregorian_date_difference (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire gdd_pkg::gdd_in_t  in_data,
  output logic                   out_valid,
  output gdd_pkg::gdd_out_t      out_data
);
  import gdd_pkg::*;

  // valid chain, one bit per stage
  logic        v1_r, v2_r, v3_r, out_valid_r;
  logic        v1_nxt;

  // input register
  gdd_in_t     in_r;

  // ordering flags, aligned with the day numbers
  logic        after1_r, before1_r;
  logic        after2_r, before2_r;
  logic [YEAR_W+MONTH_W+DAY_W-1:0] key_a, key_b;

  logic [DNUM_W-1:0]       dn_a, dn_b;
  logic signed [DIFF_W:0]  diff;
  gdd_out_t                out_nxt;
  gdd_out_t                out_r;

  // no backpressure inside: a new pair every cycle while reset is released
  assign busy   = ~rst_n;
  assign v1_nxt = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_nxt) begin
      in_r <= in_data;
    end
  end

  // two identical day number pipes, one per date
  gdd_day_num u_dn_a (
    .clk     (clk),
    .year    (in_r.year_a),
    .month   (in_r.month_a),
    .day     (in_r.day_a),
    .day_num (dn_a)
  );

  gdd_day_num u_dn_b (
    .clk     (clk),
    .year    (in_r.year_b),
    .month   (in_r.month_b),
    .day     (in_r.day_b),
    .day_num (dn_b)
  );

  // flags compare the raw fields as year, month, day
  assign key_a = {in_r.year_a, in_r.month_a, in_r.day_a};
  assign key_b = {in_r.year_b, in_r.month_b, in_r.day_b};

  always_ff @(posedge clk) begin
    after1_r  <= key_a > key_b;
    before1_r <= key_a < key_b;
    after2_r  <= after1_r;
    before2_r <= before1_r;
  end

  // difference with saturation to the output field
  always_comb begin
    diff = $signed({1'b0, dn_a}) - $signed({1'b0, dn_b});
    if (diff > DIFF_MAX) begin
      out_nxt.day_diff = DIFF_MAX[DIFF_W-1:0];
    end else if (diff < DIFF_MIN) begin
      out_nxt.day_diff = DIFF_MIN[DIFF_W-1:0];
    end else begin
      out_nxt.day_diff = diff[DIFF_W-1:0];
    end
    out_nxt.a_after_b  = after2_r;
    out_nxt.a_before_b = before2_r;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/core/gdd_checker.sv -----
// ----------------------------------------------------------------------------
// gdd_checker
// Port level checks on the date difference block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire gdd_pkg::gdd_in_t  in_data,
  input wire logic              out_valid,
  input wire gdd_pkg::gdd_out_t out_data
);
  import gdd_pkg::*;

  logic same_date;

  assign same_date = (in_data.year_a == in_data.year_b) &&
                     (in_data.month_a == in_data.month_b) &&
                     (in_data.day_a == in_data.day_b);

  // every input transfer yields a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("input transfer without a result");

  // no result without an input transfer before it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without an input transfer");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.a_after_b && out_data.a_before_b))
    else $error("both ordering flags set");

  // equal dates give a zero difference and no ordering
  a_same_date: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && same_date) |-> ##4
      (out_data.day_diff == '0 && !out_data.a_after_b && !out_data.a_before_b))
    else $error("equal dates give a nonzero result");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (.*);

`default_nettype wire
